FILE: rtl/core/pstts_pkg.sv
// ----------------------------------------------------------------------------
// pstts_pkg
// shared types and constants for the priority sleep tick task scheduler
// ----------------------------------------------------------------------------
package pstts_pkg;

    localparam int MAX_TASKS = 16;
    localparam int ID_W      = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int PRIO_W    = 16;
    localparam int SLEEP_W   = 16;
    localparam int CMD_W     = 2;
    localparam int RES_W     = 4;

    localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SLEEP  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_KILL   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_TICK,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture the incoming word
        logic scan_start; // clear position counter
        logic scan_step;  // advance position
        logic shift_step; // one chain move step
        logic tick_step;  // decrement one chain entry
        logic commit;     // apply create/kill/sleep bookkeeping
        logic emit;       // put a result into the output register
        logic emit_last;  // final result of this word
        logic emit_null;  // emit a failure/none-due word
    } ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             full;
        logic             used;
        logic             scan_done;  // insert/remove position found
        logic             shift_done;
        logic             tick_done;
        logic             tick_due;   // current entry reaches zero
        logic             out_busy;
    } stat_t;

endpackage

FILE: rtl/core/pstts_ctrl.sv
// ----------------------------------------------------------------------------
// pstts_ctrl
// command sequencer for the scheduler
// ----------------------------------------------------------------------------
module pstts_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  pstts_pkg::stat_t  stat,
    output pstts_pkg::ctrl_t  ctrl,
    output logic              idle
);

    pstts_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pstts_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pstts_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = pstts_pkg::ST_SCAN;
                end
            end
            pstts_pkg::ST_SCAN:
            begin
                priority if (stat.cmd == pstts_pkg::CMD_TICK)
                begin
                    state_next = pstts_pkg::ST_TICK;
                end
                else if (stat.cmd == pstts_pkg::CMD_SLEEP)
                begin
                    state_next = pstts_pkg::ST_OUT;
                end
                else if ((stat.cmd == pstts_pkg::CMD_CREATE && stat.full)
                         || (stat.cmd == pstts_pkg::CMD_KILL && !stat.used))
                begin
                    state_next = pstts_pkg::ST_OUT;
                end
                else if (stat.scan_done)
                begin
                    state_next = pstts_pkg::ST_SHIFT;
                end
            end
            pstts_pkg::ST_SHIFT:
            begin
                if (stat.shift_done)
                begin
                    state_next = pstts_pkg::ST_OUT;
                end
            end
            pstts_pkg::ST_TICK:
            begin
                if (stat.tick_done && !stat.out_busy)
                begin
                    state_next = pstts_pkg::ST_IDLE;
                end
            end
            pstts_pkg::ST_OUT:
            begin
                if (!stat.out_busy)
                begin
                    state_next = pstts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pstts_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        idle = 1'b0;
        unique case (state_reg)
            pstts_pkg::ST_IDLE:
            begin
                idle = 1'b1;
                ctrl.load = in_fire;
                ctrl.scan_start = in_fire;
            end
            pstts_pkg::ST_SCAN:
            begin
                ctrl.scan_step = 1'b1;
            end
            pstts_pkg::ST_SHIFT:
            begin
                ctrl.shift_step = 1'b1;
            end
            pstts_pkg::ST_TICK:
            begin
                // one chain entry per cycle, stalls while a result waits
                if (!stat.out_busy)
                begin
                    if (stat.tick_done)
                    begin
                        // closing word: none-due result, or marker ending a due run
                        ctrl.emit = 1'b1;
                        ctrl.emit_null = 1'b1;
                        ctrl.emit_last = 1'b1;
                    end
                    else
                    begin
                        ctrl.tick_step = 1'b1;
                        ctrl.emit = stat.tick_due;
                    end
                end
            end
            pstts_pkg::ST_OUT:
            begin
                if (!stat.out_busy)
                begin
                    ctrl.emit = 1'b1;
                    ctrl.emit_last = 1'b1;
                    ctrl.commit = 1'b1;
                end
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

endmodule

FILE: rtl/core/pstts_dp.sv
// ----------------------------------------------------------------------------
// pstts_dp
// task table, service chain, free stack and result register
// ----------------------------------------------------------------------------
module pstts_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pstts_pkg::ctrl_t              ctrl,
    input  logic [pstts_pkg::CMD_W-1:0]   command,
    input  logic [pstts_pkg::PRIO_W-1:0]  priority_req,
    input  logic [3:0]                    task_id,
    input  logic [pstts_pkg::SLEEP_W-1:0] sleep_ticks,
    output pstts_pkg::stat_t              stat,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pstts_pkg::RES_W-1:0]   result_task,
    output logic                          valid_res,
    output logic                          last_of_run
);

    localparam int N  = pstts_pkg::MAX_TASKS;
    localparam int IW = pstts_pkg::ID_W;
    localparam int CW = pstts_pkg::CNT_W;

    logic [pstts_pkg::PRIO_W-1:0]  prio_reg [N];
    logic [pstts_pkg::SLEEP_W-1:0] sleep_reg [N];
    logic [N-1:0]                  busy_reg;
    logic [IW-1:0]                 chain_reg [N];
    logic [IW-1:0]                 stack_reg [N];
    logic [CW-1:0]                 olen_reg;
    logic [CW-1:0]                 fdep_reg;

    logic [pstts_pkg::CMD_W-1:0]   cmd_reg;
    logic [pstts_pkg::PRIO_W-1:0]  prq_reg;
    logic [3:0]                    tid_reg;
    logic [pstts_pkg::SLEEP_W-1:0] tks_reg;
    logic [CW-1:0]                 pos_reg;
    logic [CW-1:0]                 sh_reg;

    logic                          ovalid_reg;
    logic [pstts_pkg::RES_W-1:0]   otask_reg;
    logic                          ook_reg;
    logic                          olast_reg;

    logic [IW-1:0] new_slot;
    logic [IW-1:0] tid_slot;
    logic          tid_in;
    logic          used;
    logic [IW-1:0] pos_ix;
    logic [IW-1:0] sh_ix;
    logic [IW-1:0] cur;
    logic          pos_end;
    logic          hit;
    logic [pstts_pkg::SLEEP_W-1:0] dec;
    logic          is_create;

    assign is_create = (cmd_reg == pstts_pkg::CMD_CREATE);
    assign new_slot  = stack_reg[IW'(fdep_reg - CW'(1))];
    assign tid_in    = ({{(32-4){1'b0}}, tid_reg} < N);
    assign tid_slot  = IW'(tid_reg);
    assign used      = tid_in && busy_reg[tid_slot];
    assign pos_ix    = pos_reg[IW-1:0];
    assign sh_ix     = sh_reg[IW-1:0];
    assign pos_end   = (pos_reg >= olen_reg);
    assign cur       = chain_reg[pos_ix];
    assign hit       = is_create ? (prio_reg[cur] > prq_reg) : (cur == tid_slot);
    assign dec       = sleep_reg[cur] - pstts_pkg::SLEEP_W'(1);

    always_comb
    begin
        stat.cmd        = cmd_reg;
        stat.full       = (fdep_reg == '0);
        stat.used       = used;
        stat.scan_done  = pos_end || hit;
        // create shifts up from the tail, kill shifts down toward the tail
        stat.shift_done = is_create ? (sh_reg <= pos_reg)
                                    : (sh_reg + CW'(1) >= olen_reg);
        stat.tick_done  = pos_end;
        stat.tick_due   = (dec == '0);
        stat.out_busy   = ovalid_reg && !out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= '0;
            olen_reg   <= '0;
            fdep_reg   <= CW'(N);
            ovalid_reg <= 1'b0;
            for (int i = 0; i < N; i++)
            begin
                stack_reg[i] <= IW'(i);
            end
        end
        else
        begin
            if (ovalid_reg && out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
            if (ctrl.commit && stat.cmd == pstts_pkg::CMD_CREATE && !stat.full)
            begin
                busy_reg[new_slot] <= 1'b1;
                fdep_reg <= fdep_reg - CW'(1);
                olen_reg <= olen_reg + CW'(1);
            end
            if (ctrl.commit && stat.cmd == pstts_pkg::CMD_KILL && used)
            begin
                busy_reg[tid_slot] <= 1'b0;
                stack_reg[fdep_reg[IW-1:0]] <= tid_slot;
                fdep_reg <= fdep_reg + CW'(1);
                olen_reg <= olen_reg - CW'(1);
            end
            if (ctrl.emit)
            begin
                ovalid_reg <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg <= command;
            prq_reg <= priority_req;
            tid_reg <= task_id;
            tks_reg <= sleep_ticks;
        end
        if (ctrl.scan_start)
        begin
            pos_reg <= '0;
        end
        if (ctrl.scan_step)
        begin
            if (cmd_reg == pstts_pkg::CMD_TICK)
            begin
                pos_reg <= '0;
            end
            else if (!(pos_end || hit))
            begin
                pos_reg <= pos_reg + CW'(1);
            end
            sh_reg <= is_create ? olen_reg : pos_reg;
        end
        if (ctrl.shift_step && !stat.shift_done)
        begin
            if (is_create)
            begin
                chain_reg[sh_ix] <= chain_reg[IW'(sh_reg - CW'(1))];
                sh_reg <= sh_reg - CW'(1);
            end
            else
            begin
                chain_reg[sh_ix] <= chain_reg[IW'(sh_reg + CW'(1))];
                sh_reg <= sh_reg + CW'(1);
            end
        end
        if (ctrl.commit && cmd_reg == pstts_pkg::CMD_CREATE && fdep_reg != '0)
        begin
            chain_reg[pos_ix] <= new_slot;
            prio_reg[new_slot] <= prq_reg;
            sleep_reg[new_slot] <= pstts_pkg::SLEEP_W'(1);
        end
        if (ctrl.commit && cmd_reg == pstts_pkg::CMD_SLEEP && used)
        begin
            sleep_reg[tid_slot] <= tks_reg;
        end
        if (ctrl.tick_step)
        begin
            sleep_reg[cur] <= dec;
            pos_reg <= pos_reg + CW'(1);
        end
        if (ctrl.emit)
        begin
            olast_reg <= ctrl.emit_last;
            priority if (ctrl.tick_step)
            begin
                otask_reg <= pstts_pkg::RES_W'(cur);
                ook_reg   <= 1'b1;
                // last due entry is unknown yet, so mark later via tail word
                olast_reg <= 1'b0;
            end
            else if (ctrl.emit_null)
            begin
                otask_reg <= '0;
                ook_reg   <= 1'b0;
            end
            else if (cmd_reg == pstts_pkg::CMD_CREATE)
            begin
                otask_reg <= (fdep_reg == '0) ? '0 : pstts_pkg::RES_W'(new_slot);
                ook_reg   <= (fdep_reg != '0);
            end
            else
            begin
                otask_reg <= tid_reg;
                ook_reg   <= used;
            end
        end
    end

    assign out_valid   = ovalid_reg;
    assign result_task = otask_reg;
    assign valid_res   = ook_reg;
    assign last_of_run = olast_reg;

endmodule

FILE: rtl/core/pstts_tickbuf.sv
// ----------------------------------------------------------------------------
// pstts_tickbuf
// one-word hold stage that sets last_of_run on the final due task of a tick
// ----------------------------------------------------------------------------
module pstts_tickbuf (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [pstts_pkg::RES_W-1:0] in_task,
    input  logic                        in_ok,
    input  logic                        in_last,
    input  logic                        flush,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [pstts_pkg::RES_W-1:0] out_task,
    output logic                        out_ok,
    output logic                        out_last
);

    // a non-final due word is held until the next word shows whether it was last
    logic                        hold_reg;
    logic [pstts_pkg::RES_W-1:0] htask_reg;
    logic                        hlast_reg;
    logic                        hok_reg;
    logic                        ovalid_reg;
    logic [pstts_pkg::RES_W-1:0] otask_reg;
    logic                        ook_reg;
    logic                        olast_reg;
    logic                        ofree;
    logic                        take;

    assign ofree    = !ovalid_reg || out_ready;
    assign in_ready = ofree;
    assign take     = in_valid && ofree;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (ofree)
            begin
                ovalid_reg <= 1'b0;
            end
            if (take)
            begin
                if (in_last)
                begin
                    // final word: a held due word becomes last, else this word
                    if (hold_reg)
                    begin
                        ovalid_reg <= 1'b1;
                        otask_reg  <= htask_reg;
                        ook_reg    <= hok_reg;
                        olast_reg  <= 1'b1;
                        hold_reg   <= 1'b0;
                    end
                    else
                    begin
                        ovalid_reg <= 1'b1;
                        otask_reg  <= in_task;
                        ook_reg    <= in_ok;
                        olast_reg  <= 1'b1;
                    end
                end
                else
                begin
                    if (hold_reg)
                    begin
                        ovalid_reg <= 1'b1;
                        otask_reg  <= htask_reg;
                        ook_reg    <= hok_reg;
                        olast_reg  <= hlast_reg;
                    end
                    hold_reg  <= 1'b1;
                    htask_reg <= in_task;
                    hok_reg   <= in_ok;
                    hlast_reg <= 1'b0;
                end
            end
            else if (flush && hold_reg && ofree)
            begin
                ovalid_reg <= 1'b1;
                otask_reg  <= htask_reg;
                ook_reg    <= hok_reg;
                olast_reg  <= 1'b1;
                hold_reg   <= 1'b0;
            end
        end
    end

    assign out_valid = ovalid_reg;
    assign out_task  = otask_reg;
    assign out_ok    = ook_reg;
    assign out_last  = olast_reg;

endmodule

FILE: rtl/core/priority_sleep_tick_task_scheduler.sv
// ----------------------------------------------------------------------------
// priority_sleep_tick_task_scheduler
// task table with priority-ordered service chain and tick-driven sleep counts
// ----------------------------------------------------------------------------
// One command word goes in at a time; in_ready is high only while the
// sequencer is idle and its last result word has moved into the output
// stage. Create and kill walk the service chain one entry a cycle to find
// the position, then move the rest of the chain one entry a cycle; sleep
// does no walk. A tick visits every in-use task once, one per cycle while
// the output side does not stall, and emits a word per due task in priority
// order. Every word carries result_task, valid_res and last_of_run; the
// final word of a command has last_of_run set. A tick with nothing due
// gives one word with valid_res low.
// ----------------------------------------------------------------------------
module priority_sleep_tick_task_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [15:0] priority_req,
    input  logic [3:0]  task_id,
    input  logic [15:0] sleep_ticks,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  result_task,
    output logic        valid_res,
    output logic        last_of_run
);

    pstts_pkg::ctrl_t ctrl;
    pstts_pkg::stat_t stat;
    logic             idle;
    logic             in_fire;

    // datapath result word before the last-marking stage
    logic        dp_valid;
    logic        dp_ready;
    logic [3:0]  dp_task;
    logic        dp_ok;
    logic        dp_last;

    // the sequencer also waits for the datapath result word to move on before a new word
    logic        buf_ready;

    assign in_ready = idle && !dp_valid;
    assign in_fire  = in_valid && in_ready;

    pstts_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .stat    (stat),
        .ctrl    (ctrl),
        .idle    (idle)
    );

    pstts_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .command      (command),
        .priority_req (priority_req),
        .task_id      (task_id),
        .sleep_ticks  (sleep_ticks),
        .stat         (stat),
        .out_valid    (dp_valid),
        .out_ready    (dp_ready),
        .result_task  (dp_task),
        .valid_res    (dp_ok),
        .last_of_run  (dp_last)
    );

    // tick words with valid_res low and last set are only sentinels when a
    // due word is held; the hold stage turns the held word into the last one
    pstts_tickbuf u_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dp_valid),
        .in_ready  (buf_ready),
        .in_task   (dp_task),
        .in_ok     (dp_ok),
        .in_last   (dp_last),
        .flush     (1'b0),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_task  (result_task),
        .out_ok    (valid_res),
        .out_last  (last_of_run)
    );

    assign dp_ready = buf_ready;

endmodule

FILE: sim/tb_priority_sleep_tick_task_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_priority_sleep_tick_task_scheduler
// self-checking bench: directed command table, then random task traffic,
// every result word compared against a local model of the task table
// ----------------------------------------------------------------------------
module tb_priority_sleep_tick_task_scheduler;

    localparam int N_RANDOM = 64;

    // one result word as the block presents it
    typedef struct packed {
        logic [3:0] slot;
        logic       ok;
        logic       last;
    } sched_word_t;

    // one row of the directed table; has_exp marks rows with a typed-in result
    typedef struct {
        logic [pstts_pkg::CMD_W-1:0]   cmd;
        logic [pstts_pkg::PRIO_W-1:0]  prio;
        logic [3:0]                    id;
        logic [pstts_pkg::SLEEP_W-1:0] ticks;
        bit                            has_exp;
        sched_word_t                   exp;
    } cmd_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  command = '0;
    logic [15:0] priority_req = '0;
    logic [3:0]  task_id = '0;
    logic [15:0] sleep_ticks = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [3:0]  result_task;
    logic        valid_res;
    logic        last_of_run;

    // model of the task table
    logic [pstts_pkg::PRIO_W-1:0]  m_prio  [pstts_pkg::MAX_TASKS];
    logic [pstts_pkg::SLEEP_W-1:0] m_sleep [pstts_pkg::MAX_TASKS];
    bit                            m_busy  [pstts_pkg::MAX_TASKS];
    int                 m_chain [$];   // busy slots in service order
    int                 m_free  [$];   // free stack, back is the top

    sched_word_t pending_words [$];
    int  errors = 0;
    bit  quiet_phase = 0;   // no idling on either side
    bit  hold_sink = 0;     // long receiver stall requested
    bit  driving_done = 0;

    always #6 clk = ~clk;

    priority_sleep_tick_task_scheduler u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .priority_req (priority_req),
        .task_id      (task_id),
        .sleep_ticks  (sleep_ticks),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_task  (result_task),
        .valid_res    (valid_res),
        .last_of_run  (last_of_run)
    );

    // push one word onto the expected store
    function automatic void push_word(int slot, bit ok, bit last);
        sched_word_t w;
        w.slot = slot[3:0];
        w.ok   = ok;
        w.last = last;
        pending_words.push_back(w);
    endfunction

    // advance the table model by one command and queue its words
    function automatic void schedule_cmd(logic [1:0] cmd, logic [15:0] prio,
                                         logic [3:0] id, logic [15:0] ticks);
        int pos;
        int slot;
        int due;
        bit used;
        used = m_busy[id];
        case (cmd)
            pstts_pkg::CMD_CREATE:
            begin
                if (m_free.size() == 0)
                    push_word(0, 0, 1);
                else
                begin
                    slot = m_free.pop_back();
                    m_sleep[slot] = 1;
                    m_prio[slot]  = prio;
                    m_busy[slot]  = 1;
                    // after every task of equal priority
                    pos = 0;
                    while (pos < m_chain.size() && m_prio[m_chain[pos]] <= prio)
                        pos++;
                    m_chain.insert(pos, slot);
                    push_word(slot, 1, 1);
                end
            end
            pstts_pkg::CMD_TICK:
            begin
                due = 0;
                foreach (m_chain[i])
                begin
                    slot = m_chain[i];
                    m_sleep[slot] = m_sleep[slot] - 16'd1;
                    if (m_sleep[slot] == 0)
                    begin
                        push_word(slot, 1, 0);
                        due++;
                    end
                end
                if (due == 0)
                    push_word(0, 0, 1);
                else
                    pending_words[$].last = 1'b1;
            end
            pstts_pkg::CMD_SLEEP:
            begin
                if (used)
                    m_sleep[id] = ticks;
                push_word(id, used, 1);
            end
            default:
            begin
                if (used)
                begin
                    foreach (m_chain[i])
                        if (m_chain[i] == id)
                            pos = i;
                    m_chain.delete(pos);
                    m_busy[id] = 0;
                    m_free.push_back(id);
                end
                push_word(id, used, 1);
            end
        endcase
    endfunction

    // offer one word and hold it until accepted; optional idle burst first
    task automatic send_cmd(logic [1:0] cmd, logic [15:0] prio,
                            logic [3:0] id, logic [15:0] ticks);
        if (!quiet_phase && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        command      <= cmd;
        priority_req <= prio;
        task_id      <= id;
        sleep_ticks  <= ticks;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        schedule_cmd(cmd, prio, id, ticks);
        @(negedge clk);
    endtask

    // take valid down after the last word of a stretch
    task automatic stop_send();
        in_valid <= 1'b0;
        @(negedge clk);
    endtask

    // receiver: random stall bursts, or a long hold when asked
    initial
    begin
        int hold;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_sink)
            begin
                out_ready <= 1'b0;
                for (hold = 0; hold < 400; hold++)
                    @(negedge clk);
                hold_sink = 0;
            end
            else if (!quiet_phase && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // compare every accepted result word with the oldest expectation
    always @(posedge clk)
    begin
        sched_word_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_words.size() == 0)
            begin
                $error("unexpected word slot=%0d ok=%0b last=%0b",
                       result_task, valid_res, last_of_run);
                errors++;
            end
            else
            begin
                w = pending_words.pop_front();
                if (result_task !== w.slot)
                begin
                    $error("result_task expected %0d actual %0d", w.slot, result_task);
                    errors++;
                end
                if (valid_res !== w.ok)
                begin
                    $error("valid_res expected %0b actual %0b", w.ok, valid_res);
                    errors++;
                end
                if (last_of_run !== w.last)
                begin
                    $error("last_of_run expected %0b actual %0b", w.last, last_of_run);
                    errors++;
                end
            end
        end
    end

    // random command, biased toward busy slots so sleep and kill do work
    task automatic random_cmd();
        logic [1:0]  cmd;
        logic [3:0]  id;
        logic [15:0] ticks;
        int          r;
        r = $urandom_range(0, 99);
        cmd = (r < 30) ? pstts_pkg::CMD_CREATE : (r < 60) ? pstts_pkg::CMD_TICK :
              (r < 82) ? pstts_pkg::CMD_SLEEP : pstts_pkg::CMD_KILL;
        id = 4'($urandom);
        if (m_chain.size() > 0 && $urandom_range(0, 3) != 0)
            id = 4'(m_chain[$urandom_range(0, m_chain.size() - 1)]);
        // short counts make ticks find due tasks
        ticks = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
        send_cmd(cmd, ($urandom_range(0, 1)) ? 16'($urandom) : 16'($urandom_range(0, 3)),
                 id, ticks);
    endtask

    task automatic wait_drain();
        while (pending_words.size() != 0)
            @(negedge clk);
    endtask

    // stimulus
    initial
    begin
        cmd_row_t rows [$];
        cmd_row_t row;
        int       k;
        for (k = 0; k < pstts_pkg::MAX_TASKS; k++)
        begin
            m_busy[k] = 0;
            m_free.push_back(k);
        end
        // directed rows: cmd, prio, id, ticks, has_exp, {slot, ok, last}
        rows.push_back('{pstts_pkg::CMD_TICK,   16'h0000, 4'd0,  16'h0000, 1,
                         '{4'd0, 1'b0, 1'b1}});
        rows.push_back('{pstts_pkg::CMD_SLEEP,  16'h0000, 4'd15, 16'hFFFF, 1,
                         '{4'd15, 1'b0, 1'b1}});
        rows.push_back('{pstts_pkg::CMD_KILL,   16'hFFFF, 4'd0,  16'h0000, 1,
                         '{4'd0, 1'b0, 1'b1}});
        rows.push_back('{pstts_pkg::CMD_CREATE, 16'hFFFF, 4'd0,  16'h0000, 1,
                         '{4'd15, 1'b1, 1'b1}});
        rows.push_back('{pstts_pkg::CMD_CREATE, 16'h0000, 4'd0,  16'h0000, 1,
                         '{4'd14, 1'b1, 1'b1}});
        rows.push_back('{pstts_pkg::CMD_CREATE, 16'hFFFF, 4'd0,  16'h0000, 1,
                         '{4'd13, 1'b1, 1'b1}});
        rows.push_back('{pstts_pkg::CMD_CREATE, 16'h0000, 4'd0,  16'h0000, 0,
                         '{4'd0, 1'b0, 1'b0}});
        rows.push_back('{pstts_pkg::CMD_TICK,   16'h0000, 4'd0,  16'h0000, 0,
                         '{4'd0, 1'b0, 1'b0}});
        rows.push_back('{pstts_pkg::CMD_SLEEP,  16'h0000, 4'd14, 16'h0000, 0,
                         '{4'd0, 1'b0, 1'b0}});
        rows.push_back('{pstts_pkg::CMD_SLEEP,  16'h0000, 4'd13, 16'h0002, 0,
                         '{4'd0, 1'b0, 1'b0}});
        rows.push_back('{pstts_pkg::CMD_SLEEP,  16'h0000, 4'd15, 16'hFFFF, 0,
                         '{4'd0, 1'b0, 1'b0}});
        rows.push_back('{pstts_pkg::CMD_TICK,   16'h0000, 4'd0,  16'h0000, 0,
                         '{4'd0, 1'b0, 1'b0}});
        rows.push_back('{pstts_pkg::CMD_TICK,   16'h0000, 4'd0,  16'h0000, 0,
                         '{4'd0, 1'b0, 1'b0}});
        rows.push_back('{pstts_pkg::CMD_KILL,   16'h0000, 4'd14, 16'h0000, 1,
                         '{4'd14, 1'b1, 1'b1}});
        rows.push_back('{pstts_pkg::CMD_KILL,   16'h0000, 4'd14, 16'h0000, 1,
                         '{4'd14, 1'b0, 1'b1}});
        rows.push_back('{pstts_pkg::CMD_CREATE, 16'h8000, 4'd0,  16'h0000, 1,
                         '{4'd14, 1'b1, 1'b1}});

        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[i])
        begin
            row = rows[i];
            send_cmd(row.cmd, row.prio, row.id, row.ticks);
            if (row.has_exp && pending_words[$] !== row.exp)
            begin
                $error("row %0d model word expected %p actual %p", i, row.exp,
                       pending_words[$]);
                errors++;
            end
        end
        // fill the table to full, then one create past full
        while (m_free.size() > 0)
            send_cmd(pstts_pkg::CMD_CREATE, 16'($urandom_range(0, 3)), 4'd0, 16'd0);
        send_cmd(pstts_pkg::CMD_CREATE, 16'h1234, 4'd0, 16'd0);
        // all sixteen due on one tick
        foreach (m_chain[i])
            send_cmd(pstts_pkg::CMD_SLEEP, 16'd0, 4'(m_chain[i]), 16'd1);
        send_cmd(pstts_pkg::CMD_TICK, 16'd0, 4'd0, 16'd0);

        // long receiver stall while commands keep coming
        hold_sink = 1;
        for (k = 0; k < 10; k++)
            send_cmd(pstts_pkg::CMD_TICK, 16'd0, 4'd0, 16'd0);
        // sender pause until everything has come out
        stop_send();
        wait_drain();

        for (k = 0; k < N_RANDOM; k++)
        begin
            if (k == N_RANDOM - 25)
                quiet_phase = 1;
            random_cmd();
        end
        stop_send();
        driving_done = 1;
    end

    // end of run
    initial
    begin
        wait (driving_done);
        wait (pending_words.size() == 0);
        repeat (60) @(posedge clk);
        if (errors == 0 && pending_words.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // watchdog
    initial
    begin
        #5000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
